[rtl/crcpd_pkg.sv]
// Package: item types, phase and result codes, CRC-32 byte update for the deframer.
`timescale 1ns / 1ps

package crcpd_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0]  FRAME_START = 8'hAA;
    localparam logic [7:0]  REPLY_ACK  = 8'hFA;
    localparam logic [7:0]  REPLY_NAK  = 8'hFB;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    localparam logic        MODE_LINK  = 1'b0;
    localparam logic        MODE_FINAL = 1'b1;

    typedef enum logic [3:0] {
        PH_WAIT = 4'd0,
        PH_SEQ0 = 4'd1,
        PH_SEQ1 = 4'd2,
        PH_LEN0 = 4'd3,
        PH_LEN1 = 4'd4,
        PH_DATA = 4'd5,
        PH_CRC0 = 4'd6,
        PH_CRC1 = 4'd7,
        PH_CRC2 = 4'd8,
        PH_CRC3 = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_ACCEPT   = 3'd1,
        KIND_REJECT   = 3'd2,
        KIND_IMAGE_OK = 3'd3,
        KIND_IMAGE_BAD = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_CRC  = 2'd1,
        CAUSE_SEQ  = 2'd2
    } t_cause;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [8:0] byte_offset;
        logic [15:0] packet_number;
        logic [9:0] packet_length;
        t_cause     reject_cause;
        logic [7:0] reply_byte;
    } t_out_item;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/crc32_packet_deframer_core.sv]
// Top level: request register, deframer step, result register and image CRC setting.
// A request is held in the request register, then its result in the result register.
// Throughput: one request per cycle when not stalled; CRC and phase step are combinational.
// Each request is one byte (or a finalize check) and yields zero or one result.
// Reset (i_rst_n low, synchronous): parser waits for the start byte, CRCs all ones,
// sequence counter and expected image CRC zero, both pipeline registers empty.
`timescale 1ns / 1ps

module crc32_packet_deframer_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  crcpd_pkg::t_in_item     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output crcpd_pkg::t_out_item    o_out_data,
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata
);

    // request register
    logic                   r_in_valid;
    crcpd_pkg::t_in_item    r_in;
    // result register
    logic                   r_out_valid;
    crcpd_pkg::t_out_item   r_out;
    // expected whole-image CRC
    logic [31:0]            r_expected_crc;

    logic                   advance;
    logic                   in_take;
    logic                   step;
    logic                   res_valid;
    crcpd_pkg::t_out_item   res;

    // The result register frees when empty or when its result is taken this cycle;
    // the request register then moves on and may refill in the same edge.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign step       = r_in_valid && advance;

    crcpd_deframe u_deframe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in),
        .i_expected_crc (r_expected_crc),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // bytes that give no result leave the result register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step && res_valid) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_crc <= '0;
        end else if (i_cfg_we) begin
            r_expected_crc <= i_cfg_wdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/crcpd_deframe.sv]
// Deframer parse state, CRC accumulators and result formation for one byte per step.
`timescale 1ns / 1ps

module crcpd_deframe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  crcpd_pkg::t_in_item     i_item,
    input  logic [31:0]             i_expected_crc,
    output logic                    o_res_valid,
    output crcpd_pkg::t_out_item    o_res
);

    crcpd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [crcpd_pkg::LEN_W-1:0] r_len, n_len;
    logic [crcpd_pkg::LEN_W-1:0] r_count, n_count;
    logic [23:0] r_trl, n_trl;
    logic [31:0] r_pkt_crc, n_pkt_crc;
    logic [31:0] r_tent_crc, n_tent_crc;
    logic [31:0] r_comm_crc, n_comm_crc;
    logic [15:0] r_next_seq, n_next_seq;

    logic [15:0] len16;
    logic        len_ok;
    logic [crcpd_pkg::LEN_W-1:0] count_inc;
    logic [31:0] trailer;
    crcpd_pkg::t_cause cause;
    logic        link;

    assign link      = i_step && (i_item.mode == crcpd_pkg::MODE_LINK);
    assign len16     = {i_item.rx_byte, r_len_lo};
    assign len_ok    = (len16 != 16'd0) && (len16 <= 16'(crcpd_pkg::MAX_PAYLOAD));
    assign count_inc = r_count + {{(crcpd_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign trailer   = {i_item.rx_byte, r_trl};

    always_comb begin
        if (~r_pkt_crc != trailer) begin
            cause = crcpd_pkg::CAUSE_CRC;
        end else if (r_seq != r_next_seq) begin
            cause = crcpd_pkg::CAUSE_SEQ;
        end else begin
            cause = crcpd_pkg::CAUSE_NONE;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_len_lo   = r_len_lo;
        n_len      = r_len;
        n_count    = r_count;
        n_trl      = r_trl;
        n_pkt_crc  = r_pkt_crc;
        n_tent_crc = r_tent_crc;
        n_comm_crc = r_comm_crc;
        n_next_seq = r_next_seq;
        if (link) begin
            case (r_phase)
                crcpd_pkg::PH_WAIT: begin
                    if (i_item.rx_byte == crcpd_pkg::FRAME_START) begin
                        n_phase = crcpd_pkg::PH_SEQ0;
                    end
                end
                crcpd_pkg::PH_SEQ0: begin
                    n_seq   = {8'd0, i_item.rx_byte};
                    n_phase = crcpd_pkg::PH_SEQ1;
                end
                crcpd_pkg::PH_SEQ1: begin
                    n_seq   = {i_item.rx_byte, r_seq[7:0]};
                    n_phase = crcpd_pkg::PH_LEN0;
                end
                crcpd_pkg::PH_LEN0: begin
                    n_len_lo = i_item.rx_byte;
                    n_phase  = crcpd_pkg::PH_LEN1;
                end
                crcpd_pkg::PH_LEN1: begin
                    if (len_ok) begin
                        n_len     = len16[crcpd_pkg::LEN_W-1:0];
                        n_count   = '0;
                        n_pkt_crc = crcpd_pkg::CRC_INIT;
                        n_phase   = crcpd_pkg::PH_DATA;
                    end else begin
                        n_phase   = crcpd_pkg::PH_WAIT;
                    end
                end
                crcpd_pkg::PH_DATA: begin
                    n_pkt_crc  = crcpd_pkg::crc32_byte(r_pkt_crc, i_item.rx_byte);
                    n_tent_crc = crcpd_pkg::crc32_byte(r_tent_crc, i_item.rx_byte);
                    n_count    = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = crcpd_pkg::PH_CRC0;
                    end
                end
                crcpd_pkg::PH_CRC0: begin
                    n_trl   = {16'd0, i_item.rx_byte};
                    n_phase = crcpd_pkg::PH_CRC1;
                end
                crcpd_pkg::PH_CRC1: begin
                    n_trl   = {8'd0, i_item.rx_byte, r_trl[7:0]};
                    n_phase = crcpd_pkg::PH_CRC2;
                end
                crcpd_pkg::PH_CRC2: begin
                    n_trl   = {i_item.rx_byte, r_trl[15:0]};
                    n_phase = crcpd_pkg::PH_CRC3;
                end
                crcpd_pkg::PH_CRC3: begin
                    if (cause == crcpd_pkg::CAUSE_NONE) begin
                        n_comm_crc = r_tent_crc;
                        n_next_seq = r_next_seq + 16'd1;
                    end else begin
                        n_tent_crc = r_comm_crc;
                    end
                    n_pkt_crc = crcpd_pkg::CRC_INIT;
                    n_phase   = crcpd_pkg::PH_WAIT;
                end
                default: begin
                    n_phase = crcpd_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.mode == crcpd_pkg::MODE_FINAL) begin
            o_res_valid = 1'b1;
            if (~r_comm_crc == i_expected_crc) begin
                o_res.kind       = crcpd_pkg::KIND_IMAGE_OK;
                o_res.reply_byte = crcpd_pkg::REPLY_ACK;
            end else begin
                o_res.kind       = crcpd_pkg::KIND_IMAGE_BAD;
                o_res.reply_byte = crcpd_pkg::REPLY_NAK;
            end
        end else begin
            case (r_phase)
                crcpd_pkg::PH_DATA: begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = crcpd_pkg::KIND_PAYLOAD;
                    o_res.payload_byte  = i_item.rx_byte;
                    o_res.byte_offset   = r_count[8:0];
                    o_res.packet_number = r_seq;
                    o_res.packet_length = 10'(r_len);
                end
                crcpd_pkg::PH_CRC3: begin
                    o_res_valid         = 1'b1;
                    o_res.packet_number = r_seq;
                    o_res.packet_length = 10'(r_len);
                    o_res.reject_cause  = cause;
                    if (cause == crcpd_pkg::CAUSE_NONE) begin
                        o_res.kind       = crcpd_pkg::KIND_ACCEPT;
                        o_res.reply_byte = crcpd_pkg::REPLY_ACK;
                    end else begin
                        o_res.kind       = crcpd_pkg::KIND_REJECT;
                        o_res.reply_byte = crcpd_pkg::REPLY_NAK;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= crcpd_pkg::PH_WAIT;
            r_seq      <= '0;
            r_len_lo   <= '0;
            r_len      <= '0;
            r_count    <= '0;
            r_trl      <= '0;
            r_pkt_crc  <= crcpd_pkg::CRC_INIT;
            r_tent_crc <= crcpd_pkg::CRC_INIT;
            r_comm_crc <= crcpd_pkg::CRC_INIT;
            r_next_seq <= '0;
        end else begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_len_lo   <= n_len_lo;
            r_len      <= n_len;
            r_count    <= n_count;
            r_trl      <= n_trl;
            r_pkt_crc  <= n_pkt_crc;
            r_tent_crc <= n_tent_crc;
            r_comm_crc <= n_comm_crc;
            r_next_seq <= n_next_seq;
        end
    end

endmodule
